// ===== rtl/opr_pkg.sv =====
// ----------------------------------------------------------------------------
// opr_pkg
// Shared constants, types and arithmetic helpers for polynomial reconstruction.
// ----------------------------------------------------------------------------
package opr_pkg;

  localparam int DEF_MAX_TERMS    = 512;
  localparam int DEF_MAX_EXPONENT = 7;

  localparam int COEF_W  = 48;
  localparam int EXP_W   = 15;
  localparam int COORD_W = 32;
  localparam int TC_W    = 10;
  localparam int MEM_W   = 4 * COEF_W + EXP_W;

  typedef logic signed [63:0] q32_t;

  localparam logic signed [63:0] MAG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

  // Bit offset of each exponent in the code, in multiplication order.
  function automatic logic [3:0] exp_shift(input logic [2:0] f);
    logic [3:0] s;
    unique case (f)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd6;
      3'd2:    s = 4'd3;
      3'd3:    s = 4'd9;
      default: s = 4'd12;
    endcase
    return s;
  endfunction

  function automatic logic [63:0] mag64(input q32_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Addition saturating symmetrically at +-(2^63-1).
  function automatic q32_t sadd(input q32_t a, input q32_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(MAG_MAX)) return MAG_MAX;
    if (s < -65'(MAG_MAX)) return -MAG_MAX;
    return s[63:0];
  endfunction

  function automatic logic [COEF_W-1:0] sat48(input q32_t v);
    if (v > OUT_MAX) return OUT_MAX[COEF_W-1:0];
    if (v < OUT_MIN) return OUT_MIN[COEF_W-1:0];
    return v[COEF_W-1:0];
  endfunction

endpackage

// ===== rtl/opr_term_mem.sv =====
// ----------------------------------------------------------------------------
// opr_term_mem
// Matrix term store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module opr_term_mem import opr_pkg::*; #(
  parameter int MAX_TERMS = DEF_MAX_TERMS,
  parameter int AW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [MEM_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [MEM_W-1:0] rdata
);

  logic [MEM_W-1:0] mem [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/opr_mul.sv =====
// ----------------------------------------------------------------------------
// opr_mul
// Signed Q31.32 product with rounding and saturation, built from four
// 32x32 partial products.
// ----------------------------------------------------------------------------
module opr_mul import opr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  q32_t a,
  input  q32_t b,
  output logic done,
  output q32_t result
);

  logic         busy;
  logic [2:0]   step;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [63:0]  prod;
  logic [127:0] acc;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [127:0] pp;
  logic [127:0] rnd;
  logic [63:0]  mres;
  logic [1:0]   pstep;

  // Partial order: low*low, low*high, high*low, high*high.
  always_comb begin
    opa   = step[1] ? ma[63:32] : ma[31:0];
    opb   = step[0] ? mb[63:32] : mb[31:0];
    pstep = 2'(step - 3'd1);
    unique case (pstep)
      2'd0:    pp = 128'(prod);
      2'd1:    pp = 128'(prod) << 32;
      2'd2:    pp = 128'(prod) << 32;
      default: pp = 128'(prod) << 64;
    endcase
    rnd  = acc + 128'h8000_0000;
    mres = (|rnd[127:95]) ? 64'(MAG_MAX) : {1'b0, rnd[94:32]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= mag64(a);
      mb  <= mag64(b);
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (busy) begin
      if (step < 3'd4) begin
        prod <= 64'(opa) * 64'(opb);
      end
      if (step >= 3'd1 && step <= 3'd4) begin
        acc <= acc + pp;
      end
      if (step == 3'd5) begin
        result <= neg ? -q32_t'(mres) : q32_t'(mres);
      end
    end
  end

endmodule

// ===== rtl/opr_div100.sv =====
// ----------------------------------------------------------------------------
// opr_div100
// Converts a Q7.24 position in cm to Q.32 metres: round(x * 256 / 100),
// ties away from zero, by long division one byte of quotient per cycle.
// ----------------------------------------------------------------------------
module opr_div100 import opr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] raw,
  output logic                      done,
  output q32_t                      result
);

  // The rounded dividend stays below 2^40, so five bytes cover it.
  localparam int NW = 40;
  localparam int NB = NW / 8;
  localparam logic [14:0] DIVISOR = 15'd100;
  // For every partial dividend below 25600, floor(n / 100) = (n * 5243) >> 19.
  localparam logic [26:0] RECIP = 27'd5243;

  logic          busy;
  logic [2:0]    cnt;
  logic [NW-1:0] num;
  logic [6:0]    rem;
  logic          neg;
  logic [14:0]   chunk;
  logic [26:0]   qprod;
  logic [7:0]    qd;
  logic [14:0]   qmul;
  logic [32:0]   rmag;

  always_comb begin
    chunk = {rem, num[NW-1 -: 8]};
    qprod = 27'(chunk) * RECIP;
    qd    = qprod[26:19];
    qmul  = 15'(qd) * DIVISOR;
    rmag  = raw[COORD_W-1] ? 33'(-34'(raw)) : 33'(raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(NB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend register fills with quotient bytes as it empties.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= NW'({rmag, 8'd0}) + NW'(50);
      rem <= '0;
      neg <= raw[COORD_W-1];
    end else if (busy) begin
      rem <= 7'(chunk - qmul);
      num <= {num[NW-9:0], qd};
    end
  end

  assign result = neg ? -q32_t'(num) : q32_t'(num);

endmodule

// ===== rtl/optics_polynomial_reconstruction_unit.sv =====
// A load is written to the term store when taken. An event scales its three
// positions in turn, then per term builds the monomial, one product per unit
// of exponent, then the four coefficient products on the shared multiplier.
// Throughput: one item at a time; a load is taken while a result waits.
// Reset clears control and term_count; the term store is not cleared and
// an entry must be loaded before an event reads it.
// ----------------------------------------------------------------------------
// optics_polynomial_reconstruction_unit
// Polynomial matrix reconstruction of target quantities from focal-plane data.
// ----------------------------------------------------------------------------
module optics_polynomial_reconstruction_unit import opr_pkg::*; #(
  parameter int MAX_TERMS    = DEF_MAX_TERMS,
  parameter int MAX_EXPONENT = DEF_MAX_EXPONENT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [TC_W-1:0]           cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [8:0]                term_index,
  input  logic [EXP_W-1:0]          exponent_code,
  input  logic signed [COEF_W-1:0]  coef_xptar,
  input  logic signed [COEF_W-1:0]  coef_ytar,
  input  logic signed [COEF_W-1:0]  coef_yptar,
  input  logic signed [COEF_W-1:0]  coef_delta,
  input  logic signed [COORD_W-1:0] x_focal,
  input  logic signed [COORD_W-1:0] y_focal,
  input  logic signed [COORD_W-1:0] xslope_focal,
  input  logic signed [COORD_W-1:0] yslope_focal,
  input  logic signed [COORD_W-1:0] x_target,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COEF_W-1:0]  recon_xptar,
  output logic signed [COEF_W-1:0]  recon_ytar,
  output logic signed [COEF_W-1:0]  recon_yptar,
  output logic signed [COEF_W-1:0]  recon_delta
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = (AW + 1 > TC_W) ? AW + 1 : TC_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_DIVW  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_LOAD  = 4'd4;
  localparam logic [3:0] S_MONO  = 4'd5;
  localparam logic [3:0] S_MWAIT = 4'd6;
  localparam logic [3:0] S_COEF  = 4'd7;
  localparam logic [3:0] S_CWAIT = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]        state;
  logic [TC_W-1:0]   term_count;
  logic [CW-1:0]     n_lim;
  logic [CW-1:0]     term;
  logic [1:0]        pos;
  logic [2:0]        fac;
  logic [3:0]        pw;
  logic [1:0]        ci;
  logic signed [COORD_W-1:0] raw_pos [3];
  q32_t              coord [5];
  q32_t              coef [4];
  q32_t              sum [4];
  q32_t              mono;
  logic [EXP_W-1:0]  exps;

  logic              accept;
  logic              mem_we;
  logic [MEM_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [MEM_W-1:0]  mem_rdata;
  logic              div_start;
  logic              div_done;
  q32_t              div_result;
  logic              mul_start;
  q32_t              mul_a;
  q32_t              mul_b;
  logic              mul_done;
  q32_t              mul_result;
  logic [2:0]        e_raw;
  logic [3:0]        e_lim;
  logic [2:0]        slot;
  logic              out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    n_lim = (32'(term_count) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(term_count);
    e_raw = 3'(exps >> exp_shift(fac));
    e_lim = (32'(e_raw) > MAX_EXPONENT) ? 4'(MAX_EXPONENT) : {1'b0, e_raw};
    unique case (pos)
      2'd0:    slot = 3'd0;
      2'd1:    slot = 3'd1;
      default: slot = 3'd4;
    endcase
    mem_we    = accept && !kind && (32'(term_index) < MAX_TERMS);
    mem_wdata = {exponent_code, coef_delta, coef_yptar, coef_ytar, coef_xptar};
    mem_re    = (state == S_RD);
    div_start = (state == S_DIV);
    mul_start = (state == S_MONO && fac < 3'd5 && 4'(pw) < e_lim) || (state == S_COEF);
    mul_a     = (state == S_COEF) ? coef[ci] : mono;
    mul_b     = (state == S_COEF) ? mono : coord[fac];
  end

  opr_term_mem #(.MAX_TERMS(MAX_TERMS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(term_index)),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (term[AW-1:0]),
    .rdata (mem_rdata)
  );

  opr_div100 u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .raw    (raw_pos[pos]),
    .done   (div_done),
    .result (div_result)
  );

  opr_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
    end else if (cfg_write) begin
      term_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      term      <= '0;
      pos       <= '0;
      fac       <= '0;
      pw        <= '0;
      ci        <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && kind) begin
            pos   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            if (pos == 2'd2) begin
              term  <= '0;
              state <= (n_lim == '0) ? S_DONE : S_RD;
            end else begin
              pos   <= pos + 2'd1;
              state <= S_DIV;
            end
          end
        end
        S_RD: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          fac   <= '0;
          pw    <= '0;
          state <= S_MONO;
        end
        S_MONO: begin
          if (fac == 3'd5) begin
            ci    <= '0;
            state <= S_COEF;
          end else if (pw < e_lim) begin
            state <= S_MWAIT;
          end else begin
            fac <= fac + 3'd1;
            pw  <= '0;
          end
        end
        S_MWAIT: begin
          if (mul_done) begin
            pw    <= pw + 4'd1;
            state <= S_MONO;
          end
        end
        S_COEF: begin
          state <= S_CWAIT;
        end
        S_CWAIT: begin
          if (mul_done) begin
            ci <= ci + 2'd1;
            if (ci != 2'd3) begin
              state <= S_COEF;
            end else if (term + CW'(1) == n_lim) begin
              state <= S_DONE;
            end else begin
              term  <= term + CW'(1);
              state <= S_RD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; sums are cleared whenever an event is taken.
  always_ff @(posedge clk) begin
    if (accept && kind) begin
      raw_pos[0] <= x_focal;
      raw_pos[1] <= y_focal;
      raw_pos[2] <= x_target;
      coord[2]   <= q32_t'(xslope_focal) <<< 8;
      coord[3]   <= q32_t'(yslope_focal) <<< 8;
      for (int j = 0; j < 4; j++) begin
        sum[j] <= '0;
      end
    end
    if (state == S_DIVW && div_done) begin
      coord[slot] <= div_result;
    end
    if (state == S_LOAD) begin
      for (int j = 0; j < 4; j++) begin
        coef[j] <= q32_t'($signed(mem_rdata[j*COEF_W +: COEF_W]));
      end
      exps <= mem_rdata[4*COEF_W +: EXP_W];
      mono <= ONE_Q32;
    end
    if (state == S_MWAIT && mul_done) begin
      mono <= mul_result;
    end
    if (state == S_CWAIT && mul_done) begin
      sum[ci] <= sadd(sum[ci], mul_result);
    end
    if (state == S_DONE && out_free) begin
      recon_xptar <= sat48(sum[0]);
      recon_ytar  <= sat48(sum[1]);
      recon_yptar <= sat48(sum[2]);
      recon_delta <= sat48(sum[3]);
    end
  end

endmodule

// ===== rtl/opr_checker.sv =====
// ----------------------------------------------------------------------------
// opr_checker
// Port-level checks on the reconstruction unit, bound to the top level.
// ----------------------------------------------------------------------------
module opr_checker import opr_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     kind,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [COEF_W-1:0] recon_xptar,
  input logic signed [COEF_W-1:0] recon_delta
);

  // A waiting result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(recon_xptar) && $stable(recon_delta))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // A load beat never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !kind && !out_valid |=> !out_valid)
    else $error("result after a load");

  // A result only appears at the end of event work, while input is held off.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without event work");

endmodule

bind optics_polynomial_reconstruction_unit opr_checker u_opr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .recon_xptar (recon_xptar),
  .recon_delta (recon_delta)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polynomial reconstruction unit. Matrix terms
// are loaded, then events are reconstructed under several term counts. A
// bit-exact fixed-point predictor works out every result, and each result
// beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import opr_pkg::*;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;
  localparam int   N_SLOTS    = 512;

  typedef struct packed {
    logic        kind;
    logic [8:0]  term_index;
    logic [14:0] exponent_code;
    logic [47:0] c_xptar;
    logic [47:0] c_ytar;
    logic [47:0] c_yptar;
    logic [47:0] c_delta;
    logic [31:0] xf;
    logic [31:0] yf;
    logic [31:0] xs;
    logic [31:0] ys;
    logic [31:0] xt;
  } beam_item_t;

  typedef struct packed {
    logic [47:0] xptar;
    logic [47:0] ytar;
    logic [47:0] yptar;
    logic [47:0] delta;
  } target_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [TC_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COEF_W-1:0] recon_xptar, recon_ytar, recon_yptar, recon_delta;
  beam_item_t cur_item = '0;

  beam_item_t pending_items[$];
  target_t    expected_targets[$];
  logic       calm = 1'b0;
  int         error_count = 0;

  // Predictor state: the term table and the term count.
  logic signed [47:0] tbl_xptar[N_SLOTS];
  logic signed [47:0] tbl_ytar[N_SLOTS];
  logic signed [47:0] tbl_yptar[N_SLOTS];
  logic signed [47:0] tbl_delta[N_SLOTS];
  logic [14:0]        tbl_exp[N_SLOTS];
  int unsigned        terms_in_use = 0;

  always #5 clk = ~clk;

  optics_polynomial_reconstruction_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(cur_item.kind), .term_index(cur_item.term_index),
    .exponent_code(cur_item.exponent_code),
    .coef_xptar(cur_item.c_xptar), .coef_ytar(cur_item.c_ytar),
    .coef_yptar(cur_item.c_yptar), .coef_delta(cur_item.c_delta),
    .x_focal(cur_item.xf), .y_focal(cur_item.yf),
    .xslope_focal(cur_item.xs), .yslope_focal(cur_item.ys),
    .x_target(cur_item.xt),
    .out_valid(out_valid), .out_stall(out_stall),
    .recon_xptar(recon_xptar), .recon_ytar(recon_ytar),
    .recon_yptar(recon_yptar), .recon_delta(recon_delta)
  );

  // Product in Q.32, rounded half away from zero on the magnitude, saturated.
  function automatic q32_t mul_q32(input q32_t a, input q32_t b);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    q32_t         m;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    p = {64'd0, ma} * {64'd0, mb} + 128'h8000_0000;
    if (p[127:95] != '0) m = MAG_MAX;
    else m = {1'b0, p[94:32]};
    return (a[63] != b[63]) ? -m : m;
  endfunction

  function automatic q32_t add_sat(input q32_t a, input q32_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(MAG_MAX)) return MAG_MAX;
    if (s < -65'(MAG_MAX)) return -MAG_MAX;
    return s[63:0];
  endfunction

  // A position in cm becomes metres in Q.32: raw * 256 / 100, rounded.
  function automatic q32_t scale_position(input logic [31:0] raw);
    q32_t        n;
    logic [63:0] q;
    n = {{24{raw[31]}}, raw, 8'd0};
    q = ((n[63] ? 64'(-n) : 64'(n)) + 64'd50) / 64'd100;
    return n[63] ? -q32_t'(q) : q32_t'(q);
  endfunction

  function automatic logic [47:0] clip48(input q32_t v);
    if (v > OUT_MAX) return OUT_MAX[47:0];
    if (v < OUT_MIN) return OUT_MIN[47:0];
    return v[47:0];
  endfunction

  function automatic target_t reconstruct(input beam_item_t it);
    q32_t        coord[5];
    q32_t        sum_xp, sum_yt, sum_yp, sum_de, mono;
    int unsigned fac_shift[5];
    int unsigned n, e;
    target_t     t;
    fac_shift = '{0, 6, 3, 9, 12};
    coord[0] = scale_position(it.xf);
    coord[1] = scale_position(it.yf);
    coord[2] = {{24{it.xs[31]}}, it.xs, 8'd0};
    coord[3] = {{24{it.ys[31]}}, it.ys, 8'd0};
    coord[4] = scale_position(it.xt);
    sum_xp = '0; sum_yt = '0; sum_yp = '0; sum_de = '0;
    n = (terms_in_use > N_SLOTS) ? N_SLOTS : terms_in_use;
    for (int i = 0; i < n; i++) begin
      mono = ONE_Q32;
      for (int f = 0; f < 5; f++) begin
        e = (tbl_exp[i] >> fac_shift[f]) & 7;
        for (int k = 0; k < e; k++) mono = mul_q32(mono, coord[f]);
      end
      sum_xp = add_sat(sum_xp, mul_q32(64'(tbl_xptar[i]), mono));
      sum_yt = add_sat(sum_yt, mul_q32(64'(tbl_ytar[i]), mono));
      sum_yp = add_sat(sum_yp, mul_q32(64'(tbl_yptar[i]), mono));
      sum_de = add_sat(sum_de, mul_q32(64'(tbl_delta[i]), mono));
    end
    t.xptar = clip48(sum_xp);
    t.ytar  = clip48(sum_yt);
    t.yptar = clip48(sum_yp);
    t.delta = clip48(sum_de);
    return t;
  endfunction

  function automatic void queue_item(input beam_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void absorb_item(input beam_item_t it);
    if (it.kind == KIND_LOAD) begin
      tbl_exp[it.term_index]   = it.exponent_code;
      tbl_xptar[it.term_index] = it.c_xptar;
      tbl_ytar[it.term_index]  = it.c_ytar;
      tbl_yptar[it.term_index] = it.c_yptar;
      tbl_delta[it.term_index] = it.c_delta;
    end else begin
      expected_targets.insert(expected_targets.size(), reconstruct(it));
    end
  endfunction

  // Sender: a stalled beat is held; otherwise the next item goes out or a gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) absorb_item(cur_item);
      if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
        cur_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  // Receiver: checks every result beat and stalls at random.
  always @(posedge clk) begin
    target_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_targets.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result beat");
        end else begin
          want = expected_targets.pop_front();
          check_field("xptar", want.xptar, recon_xptar);
          check_field("ytar", want.ytar, recon_ytar);
          check_field("yptar", want.yptar, recon_yptar);
          check_field("delta", want.delta, recon_delta);
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  function automatic logic [47:0] rand_coef();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 1)) return r[47:0];
    return {{12{r[35]}}, r[35:0]};
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 99) < 30) return r;
    return {{5{r[26]}}, r[26:0]};
  endfunction

  // Mostly low powers, so that long term lists stay quick.
  function automatic logic [14:0] rand_exponents();
    logic [14:0] code;
    int unsigned r;
    code = '0;
    for (int f = 0; f < 5; f++) begin
      r = $urandom_range(0, 99);
      code[3*f +: 3] = (r < 50) ? 3'd0 : (r < 85) ? 3'd1 : (r < 95) ? 3'd2 :
                       3'($urandom_range(3, 7));
    end
    return code;
  endfunction

  function automatic beam_item_t rand_item(input logic k, input logic [8:0] slot);
    beam_item_t it;
    it.kind = k;
    it.term_index = slot;
    it.exponent_code = rand_exponents();
    it.c_xptar = rand_coef();
    it.c_ytar  = rand_coef();
    it.c_yptar = rand_coef();
    it.c_delta = rand_coef();
    it.xf = rand_coord();
    it.yf = rand_coord();
    it.xs = rand_coord();
    it.ys = rand_coord();
    it.xt = rand_coord();
    return it;
  endfunction

  function automatic beam_item_t coord_event(input logic [31:0] v);
    beam_item_t it;
    it = rand_item(KIND_EVENT, 9'($urandom));
    it.xf = v; it.yf = v; it.xs = v; it.ys = v; it.xt = v;
    return it;
  endfunction

  function automatic beam_item_t term_load(input logic [8:0] slot,
                                           input logic [14:0] code,
                                           input logic [47:0] c);
    beam_item_t it;
    it = rand_item(KIND_LOAD, slot);
    it.exponent_code = code;
    it.c_xptar = c; it.c_ytar = c; it.c_yptar = c; it.c_delta = c;
    return it;
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_targets.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_term_count(input int unsigned v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= TC_W'(v);
    terms_in_use = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned tc, input int n_items,
                              input int load_pct);
    set_term_count(tc);
    for (int i = 0; i < n_items; i++)
      queue_item(rand_item(($urandom_range(0, 99) < load_pct) ?
                           KIND_LOAD : KIND_EVENT, 9'($urandom)));
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // No terms in use: an event gives zeros; first terms at the extremes.
    set_term_count(0);
    queue_item(coord_event(32'h7FFF_FFFF));
    queue_item(term_load(9'd0, 15'h7FFF, 48'h7FFF_FFFF_FFFF));
    queue_item(term_load(9'd1, 15'h0000, 48'h8000_0000_0000));
    queue_item(term_load(9'd2, 15'h1249, 48'hFFFF_FFFF_FFFF));
    queue_item(term_load(9'd511, 15'h0000, 48'h0000_0000_0001));
    wait_drained();

    set_term_count(3);
    queue_item(coord_event(32'h7FFF_FFFF));
    queue_item(coord_event(32'h8000_0000));
    queue_item(coord_event(32'h0000_0000));
    queue_item(coord_event(32'hFFFF_FFFF));
    queue_item(coord_event(32'h6400_0000));
    queue_item(coord_event(32'h0100_0000));
    queue_item(coord_event(32'h0000_0001));
    wait_drained();

    // Fill every remaining slot so that any term count is safe to use.
    for (int s = 3; s < 511; s++) begin
      queue_item(rand_item(KIND_LOAD, 9'(s)));
      if (s % 17 == 0) queue_item(rand_item(KIND_EVENT, 9'($urandom)));
    end
    wait_drained();

    random_phase(512, 4, 50);
    random_phase(1023, 3, 34);
    for (int p = 0; p < 9; p++) begin
      calm = (p == 3);
      random_phase($urandom_range(1, 8), 70, 30);
    end
    calm = 1'b0;
    random_phase(0, 6, 30);

    repeat (200) @(posedge clk);
    if (error_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #200ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
